// ----- rtl/icf_pkg.sv -----
// icf_pkg: operation codes, routing classes and request record for the constant-fold alu
// used by every module under rtl; no dependencies
`default_nettype none
package icf_pkg;
	localparam int XLEN      = 64;
	localparam int OP_W      = 5;
	localparam int FIFO_DEPTH = 4;

	localparam logic [OP_W-1:0] OP_PLUS = 5'd0;
	localparam logic [OP_W-1:0] OP_NEG  = 5'd1;
	localparam logic [OP_W-1:0] OP_LNOT = 5'd2;
	localparam logic [OP_W-1:0] OP_BNOT = 5'd3;
	localparam logic [OP_W-1:0] OP_ADD  = 5'd4;
	localparam logic [OP_W-1:0] OP_SUB  = 5'd5;
	localparam logic [OP_W-1:0] OP_MUL  = 5'd6;
	localparam logic [OP_W-1:0] OP_DIV  = 5'd7;
	localparam logic [OP_W-1:0] OP_MOD  = 5'd8;
	localparam logic [OP_W-1:0] OP_AND  = 5'd9;
	localparam logic [OP_W-1:0] OP_OR   = 5'd10;
	localparam logic [OP_W-1:0] OP_SHL  = 5'd11;
	localparam logic [OP_W-1:0] OP_SHR  = 5'd12;
	localparam logic [OP_W-1:0] OP_XOR  = 5'd13;
	localparam logic [OP_W-1:0] OP_EQ   = 5'd14;
	localparam logic [OP_W-1:0] OP_NE   = 5'd15;
	localparam logic [OP_W-1:0] OP_LT   = 5'd16;
	localparam logic [OP_W-1:0] OP_LE   = 5'd17;
	localparam logic [OP_W-1:0] OP_GT   = 5'd18;
	localparam logic [OP_W-1:0] OP_GE   = 5'd19;
	localparam logic [OP_W-1:0] OP_LAND = 5'd20;
	localparam logic [OP_W-1:0] OP_LOR  = 5'd21;

	// unit class picked by the front end
	typedef enum logic [1:0] {
		CLS_SIMPLE = 2'd0,
		CLS_MUL    = 2'd1,
		CLS_DIV    = 2'd2,
		CLS_BAD    = 2'd3
	} cls_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		cls_t            cls;
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
	} req_t;

	typedef struct packed {
		logic [XLEN-1:0] value;
		logic            bad;
	} rsp_t;
endpackage
`default_nettype wire

// ----- rtl/icf_front.sv -----
// icf_front: accepts requests, decodes the operation class, feeds the request queue
// depends on icf_pkg
`default_nettype none
module icf_front
	import icf_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [OP_W-1:0]     op,
	input  wire logic [XLEN-1:0]     a,
	input  wire logic [XLEN-1:0]     b,
	output logic                     q_valid,
	input  wire logic                q_ready,
	output req_t                     q_req
);
	localparam int PTR_W = $clog2(FIFO_DEPTH);

	req_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;
	cls_t            cls;
	logic            push, pop;

	// operation classification
	always_comb begin
		unique case (op)
			OP_MUL:                cls = CLS_MUL;
			OP_DIV, OP_MOD:        cls = CLS_DIV;
			default: cls = (op > OP_LOR) ? CLS_BAD : CLS_SIMPLE;
		endcase
	end

	assign in_ready = (cnt_q != (PTR_W+1)'(FIFO_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_valid && q_ready;
	assign q_req    = mem_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{op: op, cls: cls, a: a, b: b};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (PTR_W+1)'(FIFO_DEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_q == rd_q))
		else $error("empty queue with unequal pointers");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count missed a push");
endmodule
`default_nettype wire

// ----- rtl/icf_mul.sv -----
// icf_mul: 64x64 low-half multiplier built from three 32x32 partial products over stages
// depends on icf_pkg
`default_nettype none
module icf_mul
	import icf_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [XLEN-1:0] a,
	input  wire logic [XLEN-1:0] b,
	output logic      [XLEN-1:0] p
);
	localparam int H = XLEN/2;
	logic [XLEN-1:0] ll_s1;
	logic [H-1:0]    lh_s1, hl_s1;
	logic [XLEN-1:0] ll_s2;
	logic [H-1:0]    cross_s2;

	// stage 1: partial products (only low half of cross terms matters)
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[H-1:0] * b[H-1:0];
			lh_s1 <= H'(a[H-1:0] * b[XLEN-1:H]);
			hl_s1 <= H'(a[XLEN-1:H] * b[H-1:0]);
		end
	end

	// stage 2: fold cross terms
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s2    <= ll_s1;
			cross_s2 <= lh_s1 + hl_s1;
		end
	end

	assign p = ll_s2 + {cross_s2, {H{1'b0}}};
endmodule
`default_nettype wire

// ----- rtl/icf_div_stage.sv -----
// icf_div_stage: STEPS restoring division steps on magnitudes, one pipeline stage
// depends on icf_pkg
`default_nettype none
module icf_div_stage
	import icf_pkg::*;
#(
	parameter int STEPS = 4
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [XLEN-1:0] num_i,
	input  wire logic [XLEN-1:0] den_i,
	input  wire logic [XLEN-1:0] rem_i,
	input  wire logic [XLEN-1:0] quo_i,
	output logic      [XLEN-1:0] num_o,
	output logic      [XLEN-1:0] den_o,
	output logic      [XLEN-1:0] rem_o,
	output logic      [XLEN-1:0] quo_o
);
	logic [XLEN-1:0] n, r, q;
	logic [XLEN:0]   t;

	// shift-subtract steps, msb of numerator first
	always_comb begin
		n = num_i;
		r = rem_i;
		q = quo_i;
		t = '0;
		for (int i = 0; i < STEPS; i++) begin
			t = {r, n[XLEN-1]};
			n = {n[XLEN-2:0], 1'b0};
			if (t >= {1'b0, den_i}) begin
				t = t - {1'b0, den_i};
				q = {q[XLEN-2:0], 1'b1};
			end else begin
				q = {q[XLEN-2:0], 1'b0};
			end
			r = t[XLEN-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_o <= n;
			den_o <= den_i;
			rem_o <= r;
			quo_o <= q;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/icf_back.sv -----
// icf_back: executes queued requests in a stall-able pipeline with mul and div units
// depends on icf_pkg, icf_mul, icf_div_stage
`default_nettype none
module icf_back
	import icf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	output logic       q_ready,
	input  wire req_t  q_req,
	output logic       out_valid,
	input  wire logic  out_ready,
	output rsp_t       out_rsp
);
	localparam int DSTEPS = 4;
	localparam int NDS    = XLEN/DSTEPS;
	localparam int LAT    = NDS + 1;

	// pipeline control and per-stage tags
	logic [LAT-1:0] vld_q;
	logic           adv;
	logic [XLEN-1:0] simple;
	logic            a_neg, b_neg;
	logic [XLEN-1:0] ma, mb;
	logic [5:0]      sh;
	logic            lt, gt;

	typedef struct packed {
		cls_t            cls;
		logic            is_mod;
		logic            neg_q;
		logic            neg_r;
		logic            dz;
		logic [XLEN-1:0] val;
	} tag_t;
	tag_t tag_q [LAT];

	assign adv     = !out_valid || out_ready;
	assign q_ready = adv;

	// combinational operations, result carried in the tag pipeline
	always_comb begin
		sh = q_req.b[5:0];
		lt = $signed(q_req.a) < $signed(q_req.b);
		gt = $signed(q_req.b) < $signed(q_req.a);
		case (q_req.op)
			OP_PLUS: simple = q_req.a;
			OP_NEG:  simple = -q_req.a;
			OP_LNOT: simple = XLEN'(q_req.a == '0);
			OP_BNOT: simple = ~q_req.a;
			OP_ADD:  simple = q_req.a + q_req.b;
			OP_SUB:  simple = q_req.a - q_req.b;
			OP_AND:  simple = q_req.a & q_req.b;
			OP_OR:   simple = q_req.a | q_req.b;
			OP_SHL:  simple = q_req.a << sh;
			OP_SHR:  simple = XLEN'($signed(q_req.a) >>> sh);
			OP_XOR:  simple = q_req.a ^ q_req.b;
			OP_EQ:   simple = XLEN'(q_req.a == q_req.b);
			OP_NE:   simple = XLEN'(q_req.a != q_req.b);
			OP_LT:   simple = XLEN'(lt);
			OP_LE:   simple = XLEN'(!gt);
			OP_GT:   simple = XLEN'(gt);
			OP_GE:   simple = XLEN'(!lt);
			OP_LAND: simple = XLEN'(q_req.a != '0 && q_req.b != '0);
			OP_LOR:  simple = XLEN'(q_req.a != '0 || q_req.b != '0);
			default: simple = '0;
		endcase
		a_neg = q_req.a[XLEN-1];
		b_neg = q_req.b[XLEN-1];
		ma    = a_neg ? -q_req.a : q_req.a;
		mb    = b_neg ? -q_req.b : q_req.b;
	end

	// tag pipeline and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], q_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_q[0] <= '{cls: q_req.cls, is_mod: (q_req.op == OP_MOD),
				neg_q: a_neg ^ b_neg, neg_r: a_neg, dz: (q_req.b == '0), val: simple};
			for (int i = 1; i < LAT; i++) tag_q[i] <= tag_q[i-1];
		end
	end

	// multiplier, result carried through a delay line to line up with the tag pipeline
	logic [XLEN-1:0] prod;
	logic [XLEN-1:0] pd_q [LAT-2];
	icf_mul u_mul (.clk(clk), .en(adv), .a(q_req.a), .b(q_req.b), .p(prod));
	always_ff @(posedge clk) begin
		if (adv) begin
			pd_q[0] <= prod;
			for (int i = 1; i < LAT-2; i++) pd_q[i] <= pd_q[i-1];
		end
	end

	// divider chain, NDS stages plus input register
	logic [XLEN-1:0] dn [NDS+1];
	logic [XLEN-1:0] dd [NDS+1];
	logic [XLEN-1:0] dr [NDS+1];
	logic [XLEN-1:0] dq [NDS+1];
	always_ff @(posedge clk) begin
		if (adv) begin
			dn[0] <= ma;
			dd[0] <= mb;
			dr[0] <= '0;
			dq[0] <= '0;
		end
	end
	for (genvar g = 0; g < NDS; g++) begin : g_div
		icf_div_stage #(.STEPS(DSTEPS)) u_st (
			.clk(clk), .en(adv),
			.num_i(dn[g]), .den_i(dd[g]), .rem_i(dr[g]), .quo_i(dq[g]),
			.num_o(dn[g+1]), .den_o(dd[g+1]), .rem_o(dr[g+1]), .quo_o(dq[g+1])
		);
	end

	// output register
	tag_t t;
	logic [XLEN-1:0] dv;
	always_comb begin
		t  = tag_q[LAT-1];
		dv = t.is_mod ? (t.neg_r ? -dr[NDS] : dr[NDS])
		              : (t.neg_q ? -dq[NDS] : dq[NDS]);
	end

	// tag_q[LAT-1] lines up with dq[NDS] (input register plus NDS stages)
	// and with pd_q[LAT-3] (two multiplier stages plus LAT-2 delay registers)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (t.cls)
				CLS_MUL: out_rsp <= '{value: pd_q[LAT-3], bad: 1'b0};
				CLS_DIV: out_rsp <= '{value: t.dz ? '0 : dv, bad: 1'b0};
				CLS_BAD: out_rsp <= '{value: '0, bad: 1'b1};
				default: out_rsp <= '{value: t.val, bad: 1'b0};
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[LAT-1] && tag_q[LAT-1].cls == CLS_BAD && adv) |=> out_rsp.bad)
		else $error("bad code not flagged");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_rsp.bad) |-> (out_rsp.value == '0))
		else $error("bad code with nonzero value");
endmodule
`default_nettype wire

// ----- rtl/int_const_fold_alu_core.sv -----
// int_const_fold_alu_core: top level of the 64-bit constant-fold alu
// depends on icf_pkg, icf_front, icf_back
//
// channel   dir  tdata/tuser layout
// s_axis    in   tdata[4:0] req_type, [68:5] left_operand, [132:69] right_operand (136 bits)
// m_axis    out  tdata[63:0] result_value, [64] bad_operation (72 bits)
//
// one request per cycle sustained while m_axis is not stalled; from acceptance a request
// passes the queue, the divider pipeline (16 stages of 4 restoring steps) and the output
// register, which all classes travel in step with
// arst_n clears queue pointers and pipeline valid bits; payload registers are not reset
// a stall on m_axis freezes the back pipeline; the 4-entry queue takes up to 4 more requests
// before s_axis_tready drops
`default_nettype none
module int_const_fold_alu_core
	import icf_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [135:0] s_axis_tdata,   // req_type, left_operand, right_operand, zero pad
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic      [71:0]  m_axis_tdata    // result_value, bad_operation, zero pad
);
	logic q_valid, q_ready;
	req_t q_req;
	rsp_t rsp;

	icf_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.op(s_axis_tdata[4:0]), .a(s_axis_tdata[68:5]), .b(s_axis_tdata[132:69]),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	icf_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rsp(rsp)
	);

	assign m_axis_tdata = {7'd0, rsp.bad, rsp.value};
endmodule
`default_nettype wire
